@@ rtl/wvc_pkg.sv @@
package wvc_pkg;

  localparam int VOCAB_ENTRIES   = 1024;
  localparam int MAX_TOKEN_CHARS = 99;

  localparam int LEN_W   = 7;
  localparam int USED_W  = 11;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 24;
  localparam int ADDR_W  = 17;
  localparam int CHARS_DEPTH = VOCAB_ENTRIES * MAX_TOKEN_CHARS;

  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [LEN_W-1:0]  TOK_MAX   = LEN_W'(MAX_TOKEN_CHARS);
  localparam logic [USED_W-1:0] USED_MAX  = USED_W'(VOCAB_ENTRIES);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(MAX_TOKEN_CHARS);

  // result kind
  localparam logic [1:0] KIND_HIT  = 2'd0;
  localparam logic [1:0] KIND_NEW  = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;

  typedef struct packed {
    logic       search_init;
    logic       ent_rd;
    logic       next_ent;
    logic       clr_idx;
    logic       chr_rd;
    logic       next_chr;
    logic       cp_wr;
    logic       new_wr;
    logic       hit_wr;
    logic       load_out;
    logic [1:0] kind;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic e_end;
    logic full;
    logic wl_zero;
    logic len_eq;
    logic chr_eq;
    logic i_last;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/wvc_ctrl.sv @@
module wvc_ctrl import wvc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ENT  = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_CPRD = 3'd5;
  localparam logic [2:0] ST_CPWR = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] kind_r, kind_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.close) begin
          cmd.search_init = 1'b1;
          state_nxt = ST_ENT;
        end
      end
      ST_ENT: begin
        cmd.clr_idx = 1'b1;
        if (sts.e_end) begin
          if (sts.full) begin
            kind_nxt  = KIND_FULL;
            state_nxt = ST_OUT;
          end else if (sts.wl_zero) begin
            cmd.new_wr = 1'b1;
            kind_nxt   = KIND_NEW;
            state_nxt  = ST_OUT;
          end else begin
            state_nxt = ST_CPRD;
          end
        end else begin
          cmd.ent_rd = 1'b1;
          state_nxt  = ST_LEN;
        end
      end
      ST_LEN: begin
        if (!sts.len_eq) begin
          cmd.next_ent = 1'b1;
          state_nxt    = ST_ENT;
        end else if (sts.wl_zero) begin
          cmd.hit_wr = 1'b1;
          kind_nxt   = KIND_HIT;
          state_nxt  = ST_OUT;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.chr_rd = 1'b1;
        state_nxt  = ST_CMP;
      end
      ST_CMP: begin
        if (!sts.chr_eq) begin
          cmd.next_ent = 1'b1;
          state_nxt    = ST_ENT;
        end else if (sts.i_last) begin
          cmd.hit_wr = 1'b1;
          kind_nxt   = KIND_HIT;
          state_nxt  = ST_OUT;
        end else begin
          cmd.next_chr = 1'b1;
          state_nxt    = ST_RD;
        end
      end
      ST_CPRD: begin
        cmd.chr_rd = 1'b1;
        state_nxt  = ST_CPWR;
      end
      ST_CPWR: begin
        cmd.cp_wr = 1'b1;
        if (sts.i_last) begin
          cmd.new_wr = 1'b1;
          kind_nxt   = KIND_NEW;
          state_nxt  = ST_OUT;
        end else begin
          cmd.next_chr = 1'b1;
          state_nxt    = ST_CPRD;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= KIND_HIT;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

@@ rtl/wvc_dp.sv @@
module wvc_dp import wvc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_byte_value,
  input  logic              in_is_final,
  input  logic              in_byte_present,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_word_index,
  output logic [CNT_W-1:0]  out_word_count,
  output logic              out_is_new_word,
  output logic              out_table_full,
  input  cmd_t              cmd,
  output sts_t              sts
);

  logic [7:0]        tok_mem [0:MAX_TOKEN_CHARS-1];
  logic [7:0]        chars_mem [0:CHARS_DEPTH-1];
  logic [LEN_W-1:0]  len_mem [0:VOCAB_ENTRIES-1];
  logic [CNT_W-1:0]  cnt_mem [0:VOCAB_ENTRIES-1];

  logic [LEN_W-1:0]  raw_r, clen_r, wl_r, i_r;
  logic [USED_W-1:0] used_r, e_r;
  logic [ADDR_W-1:0] base_r;
  logic [7:0]        tok_q, chr_q;
  logic [LEN_W-1:0]  len_q;
  logic [CNT_W-1:0]  cnt_q, cnt_inc;
  logic              out_valid_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  cnt_out_r;
  logic              new_r, full_r;

  logic              is_space, is_alnum, is_upper, raw_inc, keep, accept;
  logic [LEN_W-1:0]  raw_after, clen_after;
  logic [7:0]        low_byte;
  logic [ADDR_W-1:0] chr_addr;

  assign is_space = (in_byte_value == 8'h20) ||
                    (in_byte_value >= 8'h09 && in_byte_value <= 8'h0d);
  assign is_upper = (in_byte_value >= 8'h41 && in_byte_value <= 8'h5a);
  assign is_alnum = (in_byte_value >= 8'h30 && in_byte_value <= 8'h39) || is_upper ||
                    (in_byte_value >= 8'h61 && in_byte_value <= 8'h7a);
  assign low_byte = is_upper ? (in_byte_value | 8'h20) : in_byte_value;
  assign raw_inc  = in_byte_present && !is_space;
  assign keep     = raw_inc && is_alnum && (clen_r < TOK_MAX);
  assign raw_after  = raw_r + LEN_W'(raw_inc);
  assign clen_after = clen_r + LEN_W'(keep);
  assign accept   = in_valid && !in_stall;
  assign chr_addr = base_r + ADDR_W'(i_r);
  assign cnt_inc  = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + CNT_W'(1);

  always_comb begin
    sts.close = (in_byte_present && is_space && raw_r != '0) ||
                (raw_inc && raw_after >= TOK_MAX) ||
                (in_is_final && raw_after != '0);
    sts.e_end    = (e_r == used_r);
    sts.full     = (used_r == USED_MAX);
    sts.wl_zero  = (wl_r == '0);
    sts.len_eq   = (len_q == wl_r);
    sts.chr_eq   = (chr_q == tok_q);
    sts.i_last   = (i_r + LEN_W'(1) == wl_r);
    sts.out_free = !out_valid_r || !out_stall;
  end

  // token buffer and byte accounting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r  <= '0;
      clen_r <= '0;
    end else if (accept) begin
      if (sts.close) begin
        raw_r  <= '0;
        clen_r <= '0;
      end else begin
        raw_r  <= raw_after;
        clen_r <= clen_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      tok_mem[clen_r] <= low_byte;
    end
    if (accept && sts.close) begin
      wl_r <= clen_after;
    end
    if (cmd.chr_rd) begin
      tok_q <= tok_mem[i_r];
      chr_q <= chars_mem[chr_addr];
    end
    if (cmd.cp_wr) begin
      chars_mem[chr_addr] <= tok_q;
    end
    if (cmd.ent_rd) begin
      len_q <= len_mem[e_r[IDX_W-1:0]];
      cnt_q <= cnt_mem[e_r[IDX_W-1:0]];
    end
    if (cmd.new_wr) begin
      len_mem[e_r[IDX_W-1:0]] <= wl_r;
      cnt_mem[e_r[IDX_W-1:0]] <= CNT_W'(1);
    end else if (cmd.hit_wr) begin
      cnt_mem[e_r[IDX_W-1:0]] <= cnt_inc;
    end
  end

  // search walk
  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      e_r    <= '0;
      base_r <= '0;
    end else if (cmd.next_ent) begin
      e_r    <= e_r + USED_W'(1);
      base_r <= base_r + ROW_STEP;
    end
    if (cmd.clr_idx) begin
      i_r <= '0;
    end else if (cmd.next_chr) begin
      i_r <= i_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.new_wr) begin
      used_r <= used_r + USED_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (cmd.kind)
        KIND_HIT: begin
          idx_r <= e_r[IDX_W-1:0]; cnt_out_r <= cnt_inc;  new_r <= 1'b0; full_r <= 1'b0;
        end
        KIND_NEW: begin
          idx_r <= e_r[IDX_W-1:0]; cnt_out_r <= CNT_W'(1); new_r <= 1'b1; full_r <= 1'b0;
        end
        default: begin
          idx_r <= '0; cnt_out_r <= '0; new_r <= 1'b0; full_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_word_index  = idx_r;
  assign out_word_count  = cnt_out_r;
  assign out_is_new_word = new_r;
  assign out_table_full  = full_r;

endmodule

@@ rtl/word_vocabulary_counter_core.sv @@
// channel | ports                                           | dir
// input   | in_valid in_stall in_byte_value in_is_final      | in
//         | in_byte_present                                 |
// result  | out_valid out_stall out_word_index               | out
//         | out_word_count out_is_new_word out_table_full    |
//
// a beat that does not end a token is taken into the token buffer while idle.
// a token end runs a search over the stored words: an entry with a different
// length is skipped after its length is read, an entry of equal length is
// compared char by char, and on a miss the word is appended char by char;
// the vocabulary memory is single-port and the input is stalled meanwhile.
// reset clears the counters only; the word memories need no clearing pass.
// a stalled result is held in the output register while the next beats come in.
module word_vocabulary_counter_core import wvc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte_value,
  input  logic              in_is_final,
  input  logic              in_byte_present,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_word_index,
  output logic [CNT_W-1:0]  out_word_count,
  output logic              out_is_new_word,
  output logic              out_table_full
);

  cmd_t cmd;
  sts_t sts;

  wvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  wvc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_value   (in_byte_value),
    .in_is_final     (in_is_final),
    .in_byte_present (in_byte_present),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word_index  (out_word_index),
    .out_word_count  (out_word_count),
    .out_is_new_word (out_is_new_word),
    .out_table_full  (out_table_full),
    .cmd             (cmd),
    .sts             (sts)
  );

  a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_new_word && out_table_full))
    else $error("new word flagged with full table");

  a_new_count_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_new_word) |-> (out_word_count == CNT_W'(1)))
    else $error("new word count not one");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (out_word_count == '0 && out_word_index == '0))
    else $error("full result carries data");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_table_full) |-> (out_word_count != '0))
    else $error("stored word with zero count");

endmodule
